[rtl/gdo_pkg.sv]
// Shared types, constants and calendar functions of the Gregorian date offset block.
package gdo_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MONTH = 2'd1;
  localparam logic [1:0] ST_BAD_DAY   = 2'd2;
  localparam logic [1:0] ST_BAD_YEAR  = 2'd3;

  // Direction codes.
  localparam logic DIR_ADD = 1'b0;
  localparam logic DIR_SUB = 1'b1;

  localparam logic [13:0] YEAR_MIN   = 14'd1900;
  localparam logic [13:0] YEAR_MAX   = 14'd2100;
  localparam logic [11:0] EPOCH_YEAR = 12'd1600;
  localparam logic [11:0] CYCLE_LEN  = 12'd400;
  localparam logic [8:0]  CYCLE_LAST = 9'd399;
  localparam logic [3:0]  MONTHS     = 4'd12;
  localparam logic [3:0]  JANUARY    = 4'd1;
  localparam logic [3:0]  FEBRUARY   = 4'd2;
  localparam logic [6:0]  MONTH_MAX  = 7'd12;
  localparam logic [8:0]  DAYS_LEAP  = 9'd366;
  localparam logic [8:0]  DAYS_COMM  = 9'd365;

  // Exact divisibility by 25 on 14 bits: y * inv(25) mod 2^14 is at most 16383 / 25.
  localparam logic [13:0] INV25     = 14'd7209;
  localparam logic [13:0] DIV25_MAX = 14'd655;

  typedef struct packed {
    logic        func;
    logic [13:0] in_year;
    logic [6:0]  in_month;
    logic [6:0]  in_day;
    logic [13:0] offset_days;
  } gdo_req_t;

  typedef struct packed {
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [1:0]  status;
  } gdo_res_t;

  typedef struct packed {
    logic load;
    logic check;
    logic prep;
    logic ystep;
    logic mstep;
  } gdo_cmd_t;

  typedef struct packed {
    logic bad;
    logic prep_fin;
    logic year_fin;
    logic month_fin;
  } gdo_sts_t;

  // Leap rule for any 14-bit year.
  function automatic logic leap_of_year(input logic [13:0] y);
    logic [27:0] prod;
    logic        div25;
    prod  = {14'd0, y} * {14'd0, INV25};
    div25 = (prod[13:0] <= DIV25_MAX);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  // Leap rule from the position of the year in its 400-year cycle.
  function automatic logic leap_of_cycle(input logic [8:0] c);
    return (c[1:0] == 2'b00) && !(c == 9'd100 || c == 9'd200 || c == 9'd300);
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? DAYS_LEAP : DAYS_COMM;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in a common year before the first of month m.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] days;
    case (m)
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

[rtl/gdo_ctrl.sv]
// Sequencing state machine of the Gregorian date offset block.
module gdo_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  gdo_pkg::gdo_sts_t  sts_i,
  output gdo_pkg::gdo_cmd_t  cmd_o,
  output logic               busy,
  output logic               done_o
);
  import gdo_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_YEAR  = 3'd3;
  localparam logic [2:0] S_MONTH = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.bad ? S_DONE : S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = sts_i.prep_fin ? S_MONTH : S_YEAR;
      end
      S_YEAR: begin
        cmd_o.ystep = 1'b1;
        if (sts_i.year_fin) begin
          state_d = S_MONTH;
        end
      end
      S_MONTH: begin
        cmd_o.mstep = 1'b1;
        if (sts_i.month_fin) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

[rtl/gdo_datapath.sv]
// Date registers, check logic and year and month stepping of the date offset block.
module gdo_datapath (
  input  logic               clk_i,
  input  gdo_pkg::gdo_req_t  req_i,
  input  gdo_pkg::gdo_cmd_t  cmd_i,
  output gdo_pkg::gdo_sts_t  sts_o,
  output gdo_pkg::gdo_res_t  res_o
);
  import gdo_pkg::*;

  gdo_req_t    req_q;
  logic [1:0]  err_q;
  logic [11:0] year_q;
  logic [8:0]  cyc_q;    // year position within the 400-year cycle
  logic [8:0]  doy_q;
  logic [3:0]  mon_q;
  logic [14:0] rest_q;   // days still to be placed while stepping years

  logic        in_leap;
  logic [4:0]  in_mlen;
  logic [1:0]  chk_code;
  logic [8:0]  start_doy;
  logic [11:0] cyc_off;
  logic [11:0] cyc_init;
  logic        cur_leap;
  logic [8:0]  cur_ylen;
  logic [4:0]  cur_mlen;
  logic [14:0] fwd_sum;
  logic [14:0] ylen_ext;
  logic [8:0]  cyc_inc;
  logic [8:0]  cyc_dec;

  // Start date checks: month first, then day, then year.
  always_comb begin
    in_leap = leap_of_year(req_q.in_year);
    in_mlen = month_len(req_q.in_month[3:0], in_leap);
    if (req_q.in_month == 7'd0 || req_q.in_month > MONTH_MAX) begin
      chk_code = ST_BAD_MONTH;
    end else if (req_q.in_day == 7'd0 || req_q.in_day > {2'b00, in_mlen}) begin
      chk_code = ST_BAD_DAY;
    end else if (req_q.in_year < YEAR_MIN || req_q.in_year > YEAR_MAX) begin
      chk_code = ST_BAD_YEAR;
    end else begin
      chk_code = ST_OK;
    end
  end

  assign start_doy = days_before(req_q.in_month[3:0]) + {2'b00, req_q.in_day}
                   + {8'd0, in_leap && (req_q.in_month[3:0] > FEBRUARY)};

  assign cyc_off  = req_q.in_year[11:0] - EPOCH_YEAR;
  assign cyc_init = (cyc_off >= CYCLE_LEN) ? cyc_off - CYCLE_LEN : cyc_off;

  assign cur_leap = leap_of_cycle(cyc_q);
  assign cur_ylen = year_len(cur_leap);
  assign cur_mlen = month_len(mon_q, cur_leap);
  assign ylen_ext = {6'd0, cur_ylen};
  assign fwd_sum  = {1'b0, req_q.offset_days} + {6'd0, doy_q};
  assign cyc_inc  = (cyc_q == CYCLE_LAST) ? 9'd0 : cyc_q + 9'd1;
  assign cyc_dec  = (cyc_q == 9'd0) ? CYCLE_LAST : cyc_q - 9'd1;

  always_comb begin
    sts_o.bad      = (chk_code != ST_OK);
    sts_o.prep_fin = (req_q.func == DIR_ADD) ? (fwd_sum <= ylen_ext)
                                             : ({5'd0, req_q.offset_days} < {10'd0, doy_q});
    sts_o.year_fin = (req_q.func == DIR_ADD) ? (rest_q <= ylen_ext) : (rest_q < ylen_ext);
    sts_o.month_fin = !((mon_q < MONTHS) && (doy_q > {4'd0, cur_mlen}));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.check) begin
      err_q  <= chk_code;
      year_q <= req_q.in_year[11:0];
      cyc_q  <= cyc_init[8:0];
      doy_q  <= start_doy;
      mon_q  <= JANUARY;
    end
    if (cmd_i.prep) begin
      if (req_q.func == DIR_ADD) begin
        if (sts_o.prep_fin) begin
          doy_q <= fwd_sum[8:0];
        end else begin
          rest_q <= fwd_sum - ylen_ext;
          year_q <= year_q + 12'd1;
          cyc_q  <= cyc_inc;
        end
      end else begin
        if (sts_o.prep_fin) begin
          doy_q <= doy_q - req_q.offset_days[8:0];
        end else begin
          rest_q <= {1'b0, req_q.offset_days} - {6'd0, doy_q};
          year_q <= year_q - 12'd1;
          cyc_q  <= cyc_dec;
        end
      end
    end
    if (cmd_i.ystep) begin
      if (sts_o.year_fin) begin
        doy_q <= (req_q.func == DIR_ADD) ? rest_q[8:0] : cur_ylen - rest_q[8:0];
      end else begin
        rest_q <= rest_q - ylen_ext;
        if (req_q.func == DIR_ADD) begin
          year_q <= year_q + 12'd1;
          cyc_q  <= cyc_inc;
        end else begin
          year_q <= year_q - 12'd1;
          cyc_q  <= cyc_dec;
        end
      end
    end
    if (cmd_i.mstep && !sts_o.month_fin) begin
      doy_q <= doy_q - {4'd0, cur_mlen};
      mon_q <= mon_q + 4'd1;
    end
  end

  always_comb begin
    res_o.status = err_q;
    if (err_q == ST_OK) begin
      res_o.out_year  = year_q;
      res_o.out_month = mon_q;
      res_o.out_day   = doy_q[4:0];
    end else begin
      res_o.out_year  = '0;
      res_o.out_month = '0;
      res_o.out_day   = '0;
    end
  end

endmodule

[rtl/gregorian_date_offset_top.sv]
// Top level of the Gregorian date offset block: controller plus datapath.
//
// Usage: drive a request on req_i (direction, start year, month, day and a
// day offset) and raise start. The transaction is taken at a rising edge
// where start is high and busy is low; req_i need only be valid at that edge.
// busy stays high until the result has been shown, and no new transaction
// is taken meanwhile. The result on res_o is marked by done_o for exactly
// one cycle and is taken at the edge that ends that cycle. The
// receiver cannot stall the block, so it must capture the result then.
//
// Sequence after acceptance: check the date and find its day of the year,
// place the offset in the start year, step over each year boundary
// crossed, step through each month passed, then show the result. An
// invalid start date goes straight from the check to the result. The
// block then returns to idle; only one transaction is in flight.
//
// Reset (rst_ni low, asynchronous) returns the controller to idle and drops
// busy and done_o; a transaction in progress is abandoned.
module gregorian_date_offset_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  gdo_pkg::gdo_req_t  req_i,
  output logic               busy,
  output logic               done_o,
  output gdo_pkg::gdo_res_t  res_o
);
  import gdo_pkg::*;

  gdo_cmd_t cmd;
  gdo_sts_t sts;

  // The controller sequences check, placement, year and month steps.
  gdo_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // The datapath holds the date under work and reports each step's outcome.
  gdo_datapath u_dp (
    .clk_i (clk_i),
    .req_i (req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .res_o (res_o)
  );

endmodule

[rtl/gdo_checker.sv]
// Port-level assertions for the Gregorian date offset block and their binding.
module gdo_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input gdo_pkg::gdo_res_t  res_o
);
  import gdo_pkg::*;

  // A result is only shown while a transaction is in progress.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done without busy");

  // An accepted transaction makes the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted start did not raise busy");

  // The block is free again right after its single result.
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy && !done_o)) else $error("block still busy after result");

  // Error results carry zero date fields.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status != ST_OK) |->
      (res_o.out_year == 12'd0 && res_o.out_month == 4'd0 && res_o.out_day == 5'd0))
    else $error("error result with nonzero date");

  // Good results carry a plausible month and day.
  a_ok_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == ST_OK) |->
      (res_o.out_month >= 4'd1 && res_o.out_month <= MONTHS && res_o.out_day != 5'd0))
    else $error("result date out of range");

endmodule

bind gregorian_date_offset_top gdo_checker u_gdo_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);
